/* hw/rtl/lsr_pkg.sv */
// Shared types and constants for the LIFO stack with rotate.
package lsr_pkg;

  localparam int PORT_W    = 32;
  localparam int AMT_W     = 16;
  localparam int CAP_W     = 6;
  localparam int CNT_OUT_W = 6;
  localparam int AMT_CNT_W = $clog2(AMT_W + 1);

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_PEEK   = 2'd2,
    ACT_ROTATE = 2'd3
  } lsr_action_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP,
    CELL_ROT
  } lsr_cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_ROT
  } lsr_state_e;

  typedef struct packed {
    logic               start;
    logic [AMT_W-1:0]   dividend;
  } lsr_rem_req_t;

endpackage

/* hw/rtl/lifo_stack_with_rotate_core.sv */
// Top level of the LIFO stack with rotate: control, cell chain and result register.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  in      | in        | in_valid_i / in_stall_o | action_i, push_value_i, rotate_amount_i
//  out     | out       | out_valid_o/out_stall_i | ok_o, read_value_o, entry_count_o
//  cfg     | in        | cfg_we_i               | cfg_wdata_i (capacity_limit)
//
// Push, pop and peek act when accepted; the result is registered and shows in the next
// cycle, so one transaction every cycle while the output is drained. A rotate of two or
// more entries runs the remainder unit through its 16 steps, then shifts the cell chain
// one place per cycle for up to DEPTH-1 places, then loads the result once the output
// is free. Reset empties the stack and sets the capacity to 32. Input stalls while a
// rotate runs or the held result is stalled.
module lifo_stack_with_rotate_core import lsr_pkg::*; #(
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CAP_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              action_i,
  input  logic [PORT_W-1:0]       push_value_i,
  input  logic signed [AMT_W-1:0] rotate_amount_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    ok_o,
  output logic [PORT_W-1:0]       read_value_o,
  output logic [CNT_OUT_W-1:0]    entry_count_o
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  lsr_state_e           state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CAP_W-1:0]     cap_q;
  logic [CW-1:0]        rot_q, rot_d;
  logic                 neg_q, neg_d;
  logic                 out_valid_q, out_valid_d;
  logic                 ok_q, ok_d;
  logic [PORT_W-1:0]    rd_q, rd_d;
  logic [CNT_OUT_W-1:0] cnt_out_q, cnt_out_d;
  logic                 out_load;
  logic                 out_free;
  logic                 in_acc;
  lsr_action_e          action;
  lsr_cell_op_e         cell_op;
  lsr_rem_req_t         rem_req;
  logic                 rem_done;
  logic [CW-1:0]        rem_val;
  logic                 can_push;
  logic [CW-1:0]        last_idx;
  logic [AMT_W-1:0]     amt_u;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];

  assign action   = lsr_action_e'(action_i);
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign last_idx = count_q - CW'(1);
  assign can_push = (CMPW'(count_q) < CMPW'(cap_q)) && (CMPW'(count_q) < CMPW'(DEPTH));
  assign amt_u    = $unsigned(rotate_amount_i);

  always_comb begin
    state_d          = state_q;
    count_d          = count_q;
    rot_d            = rot_q;
    neg_d            = neg_q;
    cell_op          = CELL_HOLD;
    rem_req.start    = 1'b0;
    rem_req.dividend = amt_u[AMT_W-1] ? (~amt_u + AMT_W'(1)) : amt_u;
    out_load         = 1'b0;
    ok_d             = 1'b1;
    rd_d             = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (action)
            ACT_PUSH: begin
              out_load = 1'b1;
              ok_d     = can_push;
              if (can_push) begin
                cell_op = CELL_PUSH;
                count_d = count_q + CW'(1);
              end
            end
            ACT_POP, ACT_PEEK: begin
              out_load = 1'b1;
              ok_d     = (count_q != '0);
              if (count_q != '0) begin
                rd_d = PORT_W'(cell_data[0]);
                if (action == ACT_POP) begin
                  cell_op = CELL_POP;
                  count_d = count_q - CW'(1);
                end
              end
            end
            default: begin
              if (count_q < CW'(2)) begin
                out_load = 1'b1;
              end else begin
                rem_req.start = 1'b1;
                neg_d         = amt_u[AMT_W-1];
                state_d       = ST_MOD;
              end
            end
          endcase
        end
      end
      ST_MOD: begin
        if (rem_done) begin
          // a negative distance becomes the complementary upward one
          if (neg_q && (rem_val != '0)) begin
            rot_d = count_q - rem_val;
          end else begin
            rot_d = rem_val;
          end
          state_d = ST_ROT;
        end
      end
      ST_ROT: begin
        if (rot_q != '0) begin
          cell_op = CELL_ROT;
          rot_d   = rot_q - CW'(1);
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    cnt_out_d = CNT_OUT_W'(count_d);
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      cap_q       <= CAP_W'(32);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rot_q <= rot_d;
    neg_q <= neg_d;
    if (out_load) begin
      ok_q      <= ok_d;
      rd_q      <= rd_d;
      cnt_out_q <= cnt_out_d;
    end
  end

  lsr_rem #(
    .CW (CW)
  ) u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (rem_req),
    .divisor_i (count_q),
    .done_o    (rem_done),
    .rem_o     (rem_val)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] above;
    logic [DATA_WIDTH-1:0] below;
    if (i == 0) begin : g_top
      assign above = DATA_WIDTH'(push_value_i);
    end else begin : g_mid
      assign above = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign below = cell_data[i];
    end else begin : g_inner
      assign below = cell_data[i+1];
    end
    lsr_cell #(
      .IDX        (i),
      .CW         (CW),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .op_i         (cell_op),
      .last_i       (last_idx),
      .from_above_i (above),
      .from_below_i (below),
      .wrap_i       (cell_data[0]),
      .data_o       (cell_data[i])
    );
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = ok_q;
  assign read_value_o  = rd_q;
  assign entry_count_o = cnt_out_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMPW'(count_q) <= CMPW'(DEPTH))
    else $error("entry count above depth");

  a_count_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |=> $stable(count_q))
    else $error("entry count changed during rotate");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOD) && rem_done |-> (rem_val < count_q))
    else $error("remainder not below count");

  a_rot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROT) |-> (rot_q < count_q))
    else $error("rotate distance not below count");
`endif

endmodule

/* hw/rtl/lsr_cell.sv */
// One stack cell: holds a word and shifts toward either neighbor.
module lsr_cell import lsr_pkg::*; #(
  parameter int IDX        = 0,
  parameter int CW         = 6,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  lsr_cell_op_e          op_i,
  input  logic [CW-1:0]         last_i,
  input  logic [DATA_WIDTH-1:0] from_above_i,
  input  logic [DATA_WIDTH-1:0] from_below_i,
  input  logic [DATA_WIDTH-1:0] wrap_i,
  output logic [DATA_WIDTH-1:0] data_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    case (op_i)
      CELL_PUSH: data_d = from_above_i;
      CELL_POP:  data_d = from_below_i;
      // the top word wraps around into the lowest occupied cell
      CELL_ROT:  data_d = (last_i == CW'(IDX)) ? wrap_i : from_below_i;
      default:   data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* hw/rtl/lsr_rem.sv */
// Bit-serial restoring remainder unit: dividend modulo a narrow divisor.
module lsr_rem import lsr_pkg::*; #(
  parameter int CW = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lsr_rem_req_t  req_i,
  input  logic [CW-1:0] divisor_i,
  output logic          done_o,
  output logic [CW-1:0] rem_o
);

  logic [CW-1:0]        rem_q, rem_d;
  logic [AMT_W-1:0]     shf_q, shf_d;
  logic [AMT_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic [CW:0]          trial;
  logic [CW:0]          diff;

  assign trial = {rem_q, shf_q[AMT_W-1]};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    rem_d  = rem_q;
    shf_d  = shf_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (req_i.start) begin
      rem_d  = '0;
      shf_d  = req_i.dividend;
      cnt_d  = AMT_CNT_W'(AMT_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        // subtract when the trial value reaches the divisor
        rem_d = (trial >= {1'b0, divisor_i}) ? diff[CW-1:0] : trial[CW-1:0];
        shf_d = {shf_q[AMT_W-2:0], 1'b0};
        cnt_d = cnt_q - AMT_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    shf_q <= shf_d;
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign rem_o  = rem_q;

endmodule

/* test/tb.sv */
// Self-checking testbench for the LIFO stack with rotate core.
module tb;
  import lsr_pkg::*;

  localparam int DEPTH       = 32;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 64;
  localparam int REPORT_MAX  = 10;

  typedef struct {
    logic                 ok;
    logic [PORT_W-1:0]    value;
    logic [CNT_OUT_W-1:0] count;
  } stack_result_t;

  logic                    clk_i           = 1'b0;
  logic                    rst_ni          = 1'b0;
  logic                    cfg_we_i        = 1'b0;
  logic [CAP_W-1:0]        cfg_wdata_i     = '0;
  logic                    in_valid_i      = 1'b0;
  logic                    in_stall_o;
  logic [1:0]              action_i        = ACT_PUSH;
  logic [PORT_W-1:0]       push_value_i    = '0;
  logic signed [AMT_W-1:0] rotate_amount_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i     = 1'b0;
  logic                    ok_o;
  logic [PORT_W-1:0]       read_value_o;
  logic [CNT_OUT_W-1:0]    entry_count_o;

  // Shadow copy of the stack and its capacity register
  logic [PORT_W-1:0] stack_mem [DEPTH];
  int                stack_fill = 0;
  logic [CAP_W-1:0]  capacity   = 6'd32;
  stack_result_t     pending_results [$];

  int unsigned error_cnt    = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned cap_writes   = 0;
  int unsigned stall_pct    = 0;
  int unsigned action_cnt [4] = '{0, 0, 0, 0};

  lifo_stack_with_rotate_core #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (PORT_W)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .push_value_i    (push_value_i),
    .rotate_amount_i (rotate_amount_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .ok_o            (ok_o),
    .read_value_o    (read_value_o),
    .entry_count_o   (entry_count_o)
  );

  always #10 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // Compare every output transaction with the oldest expected result
  always @(posedge clk_i) begin : check_results
    stack_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        error_cnt++;
        if (error_cnt <= REPORT_MAX)
          $display("unexpected result: ok=%0b value=%h count=%0d", ok_o, read_value_o,
                   entry_count_o);
      end else begin
        want = pending_results.pop_front();
        if (ok_o !== want.ok || read_value_o !== want.value ||
            entry_count_o !== want.count) begin
          error_cnt++;
          if (error_cnt <= REPORT_MAX)
            $display("result %0d mismatch: ok %0b/%0b value %h/%h count %0d/%0d (exp/got)",
                     results_seen, want.ok, ok_o, want.value, read_value_o, want.count,
                     entry_count_o);
        end
      end
    end
  end

  // Apply one request to the shadow stack and queue the result it should give
  task automatic stack_predict(lsr_action_e act, logic [PORT_W-1:0] word,
                               logic signed [AMT_W-1:0] amt);
    stack_result_t     res;
    logic [PORT_W-1:0] shifted [DEPTH];
    int                limit;
    int                n;
    int                mag;
    int                shift_by;
    res.ok    = 1'b0;
    res.value = '0;
    limit     = (capacity > DEPTH) ? DEPTH : int'(capacity);
    n         = stack_fill;
    case (act)
      ACT_PUSH: begin
        if (n < limit) begin
          stack_mem[n] = word;
          stack_fill++;
          res.ok = 1'b1;
        end
      end
      ACT_POP, ACT_PEEK: begin
        if (n > 0) begin
          res.value = stack_mem[n-1];
          if (act == ACT_POP) stack_fill--;
          res.ok = 1'b1;
        end
      end
      default: begin
        res.ok = 1'b1;
        if (n > 1) begin
          // Negative distances turn into the complementary upward shift
          if (amt < 0) begin
            mag      = -int'(amt);
            shift_by = (mag % n == 0) ? 0 : n - mag % n;
          end else begin
            shift_by = int'(amt) % n;
          end
          for (int i = 0; i < n; i++) shifted[(i + shift_by) % n] = stack_mem[i];
          for (int i = 0; i < n; i++) stack_mem[i] = shifted[i];
        end
      end
    endcase
    res.count = stack_fill[CNT_OUT_W-1:0];
    pending_results.push_back(res);
  endtask

  task automatic send_item(lsr_action_e act, logic [PORT_W-1:0] word,
                           logic signed [AMT_W-1:0] amt);
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    action_i        <= act;
    push_value_i    <= word;
    rotate_amount_i <= amt;
    do @(posedge clk_i); while (in_stall_o);
    stack_predict(act, word, amt);
    action_cnt[act]++;
  endtask

  task automatic hold_input(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  task automatic wait_drained(int unsigned tail);
    hold_input(1);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    wait_drained(4);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    capacity = value;
    cap_writes++;
  endtask

  task automatic test_empty_stack();
    send_item(ACT_POP, 32'h1234_5678, 16'sd0);
    send_item(ACT_PEEK, 32'h0, 16'sd0);
    send_item(ACT_ROTATE, 32'h0, 16'sd5);
    send_item(ACT_ROTATE, 32'h0, -16'sd1);
    wait_drained(4);
  endtask

  task automatic test_single_entry();
    send_item(ACT_PUSH, 32'hFFFF_FFFF, 16'sd0);
    send_item(ACT_ROTATE, 32'h0, 16'sh8000);
    send_item(ACT_PEEK, 32'h0, 16'sd0);
    send_item(ACT_POP, 32'h0, 16'sd0);
    send_item(ACT_PUSH, 32'h0, 16'sd0);
    send_item(ACT_POP, 32'h0, 16'sd0);
    wait_drained(4);
  endtask

  // Full stack at a small capacity, rotate extremes, then capacity below the count
  task automatic test_capacity_edges();
    write_capacity(6'd3);
    send_item(ACT_PUSH, 32'h8000_0001, 16'sd0);
    send_item(ACT_PUSH, 32'h5555_AAAA, 16'sd0);
    send_item(ACT_PUSH, 32'h0F0F_F0F0, 16'sd0);
    send_item(ACT_PUSH, 32'hDEAD_0000, 16'sd0);
    send_item(ACT_ROTATE, 32'h0, 16'sd1);
    send_item(ACT_ROTATE, 32'h0, -16'sd1);
    send_item(ACT_ROTATE, 32'h0, 16'sh7FFF);
    send_item(ACT_ROTATE, 32'h0, 16'sh8000);
    send_item(ACT_ROTATE, 32'h0, 16'sd3);
    send_item(ACT_ROTATE, 32'h0, -16'sd6);
    send_item(ACT_PEEK, 32'h0, 16'sd0);
    write_capacity(6'd1);
    send_item(ACT_PUSH, 32'h1111_1111, 16'sd0);
    send_item(ACT_POP, 32'h0, 16'sd0);
    write_capacity(6'd0);
    send_item(ACT_PUSH, 32'h2222_2222, 16'sd0);
    send_item(ACT_POP, 32'h0, 16'sd0);
    send_item(ACT_POP, 32'h0, 16'sd0);
    send_item(ACT_POP, 32'h0, 16'sd0);
    wait_drained(4);
  endtask

  function automatic lsr_action_e pick_action(int unsigned push_weight);
    int unsigned roll;
    int unsigned rest;
    roll = $urandom_range(99);
    rest = 100 - push_weight;
    if (roll < push_weight) return ACT_PUSH;
    if (roll < push_weight + rest * 2 / 5) return ACT_POP;
    if (roll < push_weight + rest * 3 / 5) return ACT_PEEK;
    return ACT_ROTATE;
  endfunction

  function automatic logic signed [AMT_W-1:0] pick_amount();
    int off;
    case ($urandom_range(3))
      0: return AMT_W'($urandom_range(65535));
      1: begin
        off = $urandom_range(80);
        return AMT_W'(off - 40);
      end
      2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      default: begin
        // Multiple of the current count: nothing should move
        off = stack_fill * $urandom_range(4);
        return $urandom_range(1) ? AMT_W'(off) : AMT_W'(-off);
      end
    endcase
  endfunction

  task automatic test_random_traffic(int unsigned total);
    int unsigned sent;
    int unsigned phase;
    int unsigned push_weight;
    int unsigned gap_max;
    int unsigned burst;
    int unsigned in_phase;
    logic [CAP_W-1:0] cap_val;
    logic [PORT_W-1:0] word;
    lsr_action_e act;
    sent  = 0;
    phase = 0;
    while (sent < total) begin
      case (phase % 6)
        0: cap_val = 6'd32;
        1: cap_val = 6'd63;
        2: cap_val = 6'($urandom_range(2, 31));
        3: cap_val = 6'd1;
        4: cap_val = 6'($urandom_range(1, 32));
        default: cap_val = (phase == 5) ? 6'd0 : 6'($urandom_range(1, 63));
      endcase
      write_capacity(cap_val);
      case (phase % 3)
        0: push_weight = 70;
        1: push_weight = 35;
        default: push_weight = 15;
      endcase
      case ($urandom_range(2))
        0: stall_pct = 0;
        1: stall_pct = 25;
        default: stall_pct = 60;
      endcase
      gap_max  = (phase % 4 == 0) ? 0 : $urandom_range(1, 8);
      in_phase = 0;
      while (in_phase < 65 && sent < total) begin
        burst = $urandom_range(1, 10);
        repeat (burst) begin
          act  = pick_action(push_weight);
          word = ($urandom_range(3) == 0) ? {PORT_W{1'($urandom_range(1))}} : $urandom;
          send_item(act, word, (act == ACT_ROTATE) ? pick_amount() : 16'($urandom));
          in_phase++;
          sent++;
        end
        hold_input($urandom_range(0, gap_max));
      end
      wait_drained(4);
      phase++;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_stack();
    test_single_entry();
    test_capacity_edges();
    test_random_traffic(650);
    stall_pct = 0;
    wait_drained(TAIL_CYCLES);
    $display("covered %0d push, %0d pop, %0d peek and %0d rotate transactions",
             action_cnt[ACT_PUSH], action_cnt[ACT_POP], action_cnt[ACT_PEEK],
             action_cnt[ACT_ROTATE]);
    $display("checked %0d results over %0d capacity settings, %0d errors",
             results_seen, cap_writes, error_cnt);
    if (error_cnt == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/lsr_pkg.sv
hw/rtl/lsr_cell.sv
hw/rtl/lsr_rem.sv
hw/rtl/lifo_stack_with_rotate_core.sv
test/tb.sv
